### hdl/tilt_compensated_foot_placement_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt-compensated foot placement core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_FOOT_PLACEMENT_CORE_DEFINES_SVH
`define TILT_COMPENSATED_FOOT_PLACEMENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TCFP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tcfp: assertion failed");
// Next-cycle implication
`define TCFP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tcfp: assertion failed");
`else
`define TCFP_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define TCFP_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

### hdl/tcfp_pkg.sv
// ----------------------------------------------------------------------------
// tcfp_pkg
// Types, command codes and constants shared by the foot placement core.
// ----------------------------------------------------------------------------
package tcfp_pkg;

  localparam int STEP_W = 5;   // step counter width (max 32 steps per unit)
  localparam int MUL_W  = 34;  // multiplier operand width

  localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;

  localparam logic [31:0] DEAD_ZONE_Q30 = 32'd35433480;
  localparam logic signed [19:0] LAT_MAX    = 20'sd2880;
  localparam logic signed [19:0] FWD_MAX    = 20'sd2880;
  localparam logic signed [19:0] HEIGHT_MAX = 20'sd32767;

  // Elementary CORDIC angles atan(2^-i), Q30
  localparam logic [30:0] ATAN_Q30 [0:23] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127
  };

  typedef enum logic [2:0] {
    CFG_WINDOW_START      = 3'd0,
    CFG_WINDOW_END_MARGIN = 3'd1,
    CFG_STEP_LENGTH       = 3'd2,
    CFG_HALF_FOOT_SPACING = 3'd3,
    CFG_NOMINAL_HEIGHT    = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_GAIN_SQ_LOAD,
    OP_SQ_STEP,
    OP_GAIN_DIV_LOAD,
    OP_DIV_STEP,
    OP_GAIN_SAVE,
    OP_LOAD,
    OP_MAG_SQ_LOAD,
    OP_MAG_SAVE,
    OP_TERM_DIV_LOAD,
    OP_TERM_SAVE,
    OP_TERM_ZERO,
    OP_CRD_LOAD,
    OP_CRD_STEP,
    OP_CRD_SAVE,
    OP_ROT_SAVE,
    OP_COMMIT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RR,
    MUL_PP,
    MUL_R_DM,
    MUL_P_DM,
    MUL_X0_C1,
    MUL_Y0_S1,
    MUL_X0_S1,
    MUL_Y0_C1,
    MUL_X1_S2,
    MUL_Y2_C2,
    MUL_X1_C2,
    MUL_Y2_S2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD,
    ACC_SUB
  } acc_mode_t;

  typedef enum logic [4:0] {
    S_G_LOAD, S_G_SQRT, S_G_DLOAD, S_G_DIV, S_G_SAVE,
    S_IDLE, S_MAG, S_M_LOAD, S_M_SQRT, S_M_SAVE,
    S_T_CHK, S_T_MUL, S_T_DLOAD, S_T_DIV, S_T_SAVE,
    S_WIN, S_C_LOAD, S_C_STEP, S_C_SAVE, S_ROT, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t            op;
    mul_sel_t          msel;
    acc_mode_t         amode;
    logic [STEP_W-1:0] idx;
  } tcfp_cmd_t;

  typedef struct packed {
    logic mag_over;
    logic in_window;
  } tcfp_stat_t;

  // Round a length with 14 extra fraction bits to 1/64 mm, half up
  function automatic logic signed [19:0] to_units(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd8192;
    return t[33:14];
  endfunction

endpackage

### hdl/tcfp_item_if.sv
// ----------------------------------------------------------------------------
// tcfp_item_if
// Input channel: one control tick of tilt, phase and leg information.
// ----------------------------------------------------------------------------
interface tcfp_item_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic [7:0]        phase_count;
  logic              support_is_left;
  logic              support_leg;
  logic              restart;

  modport source (output valid, roll_angle, pitch_angle, phase_count,
                  support_is_left, support_leg, restart, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, phase_count,
                  support_is_left, support_leg, restart, output ready);
endinterface

### hdl/tcfp_result_if.sv
// ----------------------------------------------------------------------------
// tcfp_result_if
// Output channel: corrected offsets, swing targets and hip height.
// ----------------------------------------------------------------------------
interface tcfp_result_if;
  logic              valid;
  logic              ready;
  logic              corrected;
  logic [11:0]       lateral_offset;
  logic signed [12:0] forward_offset;
  logic [14:0]       swing_lateral;
  logic signed [12:0] swing_forward;
  logic [14:0]       hip_height;

  modport source (output valid, corrected, lateral_offset, forward_offset,
                  swing_lateral, swing_forward, hip_height, input ready);
  modport sink   (input valid, corrected, lateral_offset, forward_offset,
                  swing_lateral, swing_forward, hip_height, output ready);
endinterface

### hdl/tcfp_ctrl.sv
// ----------------------------------------------------------------------------
// tcfp_ctrl
// Sequencer: gain setup after reset, then per item magnitude, tilt terms,
// two CORDIC rotations, leg vector rotation, commit and result hand-off.
// ----------------------------------------------------------------------------
module tcfp_ctrl
  import tcfp_pkg::*;
#(
  parameter int CORDIC_ITERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  tcfp_stat_t stat,
  output tcfp_cmd_t  cmd
);

  localparam logic [STEP_W-1:0] LAST_IT = STEP_W'(CORDIC_ITERS - 1);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [STEP_W-1:0] gi, gi_next;
  logic              axis, axis_next;
  logic              out_valid, out_valid_next;

  assign result_valid = out_valid;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_G_LOAD;
      cnt       <= '0;
      gi        <= '0;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      gi        <= gi_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    gi_next        = gi;
    axis_next      = axis;
    out_valid_next = out_valid & ~result_ready;
    item_ready     = 1'b0;
    cmd.op         = OP_NOP;
    cmd.msel       = MUL_NONE;
    cmd.amode      = ACC_HOLD;
    cmd.idx        = '0;

    case (state)
      // Gain setup: product of 1/sqrt(1+2^-2i)
      S_G_LOAD: begin
        cmd.op     = OP_GAIN_SQ_LOAD;
        cmd.idx    = gi;
        cnt_next   = '0;
        state_next = S_G_SQRT;
      end
      S_G_SQRT: begin
        cmd.op  = OP_SQ_STEP;
        cmd.idx = cnt;
        if (cnt == SQRT_LAST) begin
          state_next = S_G_DLOAD;
        end
        cnt_next = (cnt == SQRT_LAST) ? '0 : cnt + 1'b1;
      end
      S_G_DLOAD: begin
        cmd.op     = OP_GAIN_DIV_LOAD;
        cnt_next   = '0;
        state_next = S_G_DIV;
      end
      S_G_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cmd.idx = cnt;
        if (cnt == DIV_LAST) begin
          state_next = S_G_SAVE;
        end
        cnt_next = (cnt == DIV_LAST) ? '0 : cnt + 1'b1;
      end
      S_G_SAVE: begin
        cmd.op = OP_GAIN_SAVE;
        if (gi == LAST_IT) begin
          state_next = S_IDLE;
        end else begin
          gi_next    = gi + 1'b1;
          state_next = S_G_LOAD;
        end
      end

      // Wait for an item
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          state_next = S_MAG;
        end
      end

      // r^2 + p^2
      S_MAG: begin
        case (cnt[1:0])
          2'd0: cmd.msel = MUL_RR;
          2'd1: begin
            cmd.amode = ACC_SET;
            cmd.msel  = MUL_PP;
          end
          default: cmd.amode = ACC_ADD;
        endcase
        cnt_next = cnt + 1'b1;
        if (cnt[1:0] == 2'd2) begin
          state_next = S_M_LOAD;
        end
      end
      S_M_LOAD: begin
        cmd.op     = OP_MAG_SQ_LOAD;
        cnt_next   = '0;
        state_next = S_M_SQRT;
      end
      S_M_SQRT: begin
        cmd.op  = OP_SQ_STEP;
        cmd.idx = cnt;
        if (cnt == SQRT_LAST) begin
          state_next = S_M_SAVE;
        end
        cnt_next = (cnt == SQRT_LAST) ? '0 : cnt + 1'b1;
      end
      S_M_SAVE: begin
        cmd.op     = OP_MAG_SAVE;
        state_next = S_T_CHK;
      end

      // Tilt terms past the dead zone
      S_T_CHK: begin
        if (stat.mag_over) begin
          axis_next  = 1'b0;
          state_next = S_T_MUL;
        end else begin
          cmd.op     = OP_TERM_ZERO;
          state_next = S_WIN;
        end
      end
      S_T_MUL: begin
        cmd.msel   = axis ? MUL_P_DM : MUL_R_DM;
        state_next = S_T_DLOAD;
      end
      S_T_DLOAD: begin
        cmd.op     = OP_TERM_DIV_LOAD;
        cnt_next   = '0;
        state_next = S_T_DIV;
      end
      S_T_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cmd.idx = cnt;
        if (cnt == DIV_LAST) begin
          state_next = S_T_SAVE;
        end
        cnt_next = (cnt == DIV_LAST) ? '0 : cnt + 1'b1;
      end
      S_T_SAVE: begin
        cmd.op  = OP_TERM_SAVE;
        cmd.idx = {{(STEP_W-1){1'b0}}, axis};
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_T_MUL;
        end else begin
          state_next = S_WIN;
        end
      end

      // Skip the rotation outside the gait window
      S_WIN: begin
        axis_next  = 1'b0;
        state_next = stat.in_window ? S_C_LOAD : S_EMIT;
      end

      // Sin and cos of roll, then pitch
      S_C_LOAD: begin
        cmd.op     = OP_CRD_LOAD;
        cmd.idx    = {{(STEP_W-1){1'b0}}, axis};
        cnt_next   = '0;
        state_next = S_C_STEP;
      end
      S_C_STEP: begin
        cmd.op  = OP_CRD_STEP;
        cmd.idx = cnt;
        if (cnt == LAST_IT) begin
          state_next = S_C_SAVE;
        end
        cnt_next = (cnt == LAST_IT) ? '0 : cnt + 1'b1;
      end
      S_C_SAVE: begin
        cmd.op   = OP_CRD_SAVE;
        cmd.idx  = {{(STEP_W-1){1'b0}}, axis};
        cnt_next = '0;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_C_LOAD;
        end else begin
          state_next = S_ROT;
        end
      end

      // Four dot products: multiply, set, multiply, add or subtract, save
      S_ROT: begin
        case (cnt[1:0])
          2'd0: begin
            case (cnt[3:2])
              2'd0:    cmd.msel = MUL_X0_C1;
              2'd1:    cmd.msel = MUL_X0_S1;
              2'd2:    cmd.msel = MUL_X1_S2;
              default: cmd.msel = MUL_X1_C2;
            endcase
          end
          2'd1: begin
            cmd.amode = ACC_SET;
            case (cnt[3:2])
              2'd0:    cmd.msel = MUL_Y0_S1;
              2'd1:    cmd.msel = MUL_Y0_C1;
              2'd2:    cmd.msel = MUL_Y2_C2;
              default: cmd.msel = MUL_Y2_S2;
            endcase
          end
          2'd2: begin
            cmd.amode = (cnt[3:2] == 2'd0 || cnt[3:2] == 2'd3) ? ACC_SUB : ACC_ADD;
          end
          default: begin
            cmd.op  = (cnt[3:2] == 2'd3) ? OP_COMMIT : OP_ROT_SAVE;
            cmd.idx = {{(STEP_W-2){1'b0}}, cnt[3:2]};
          end
        endcase
        cnt_next = cnt + 1'b1;
        if (cnt[3:0] == 4'd15) begin
          cnt_next   = '0;
          state_next = S_EMIT;
        end
      end

      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid || result_ready) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/tcfp_dpath.sv
// ----------------------------------------------------------------------------
// tcfp_dpath
// Registers, shared multiplier, bit-serial square root and divider, CORDIC
// rotator, kept offsets and the output register.
// ----------------------------------------------------------------------------
module tcfp_dpath
  import tcfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tcfp_cmd_t          cmd,
  output tcfp_stat_t         stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic [7:0]         phase_count,
  input  logic               support_is_left,
  input  logic               restart,
  output logic               corrected,
  output logic [11:0]        lateral_offset,
  output logic signed [12:0] forward_offset,
  output logic [14:0]        swing_lateral,
  output logic signed [12:0] swing_forward,
  output logic [14:0]        hip_height
);

  // Configuration
  logic [7:0]  window_start, window_end_margin, step_length_phases;
  logic [12:0] half_foot_spacing;
  logic [14:0] nominal_height;

  // Kept state
  logic [11:0]        lateral_acc;
  logic signed [12:0] forward_acc;
  logic [14:0]        height_acc;
  logic [14:0]        swing_lat_reg;
  logic signed [12:0] swing_fwd_reg;

  // Working registers
  logic signed [15:0]      r_q, p_q;
  logic                    left_q, win_q, over_q;
  logic signed [63:0]      prod, acc;
  logic [63:0]             sq_v, sq_res;
  logic [31:0]             mag;
  logic [32:0]             dv_rem;
  logic [30:0]             dv_lo, dv_q;
  logic [31:0]             dv_den;
  logic [30:0]             gain;
  logic signed [31:0]      rt, pt;
  logic signed [MUL_W-1:0] cx, cy;
  logic signed [32:0]      cz;
  logic signed [MUL_W-1:0] c1, s1, c2, s2, x1, lat_v, fwd_v;

  // Combinational
  logic signed [MUL_W-1:0]   ma, mb, x0, y0, y2, cr_dx, cr_dy;
  logic signed [2*MUL_W-1:0] mul_full;
  logic [16:0]               r_abs, p_abs;
  logic signed [13:0]        lat_diff;
  logic signed [9:0]         win_end;
  logic                      win_hit;
  logic [63:0]               sq_bit, sq_sum, gain_sq_in;
  logic [33:0]               dv_trial;
  logic                      dv_ge;
  logic signed [32:0]        cr_at;
  logic                      term_neg;
  logic signed [31:0]        term_v;
  logic signed [19:0]        lat_u, fwd_u, h_u;
  logic [11:0]               lat_c;
  logic signed [12:0]        fwd_c;
  logic [14:0]               h_c;

  assign stat.mag_over  = over_q;
  assign stat.in_window = win_q;

  // Operand forming and the shared multiplier
  always_comb begin
    r_abs    = r_q[15] ? (17'd0 - {r_q[15], r_q}) : {1'b0, r_q};
    p_abs    = p_q[15] ? (17'd0 - {p_q[15], p_q}) : {1'b0, p_q};
    lat_diff = $signed({2'b00, lateral_acc}) - $signed({1'b0, half_foot_spacing});
    x0       = $signed({5'b0, height_acc, 14'b0});
    y0       = $signed({{6{lat_diff[13]}}, lat_diff, 14'b0});
    y2       = $signed({{7{forward_acc[12]}}, forward_acc, 14'b0});
    ma       = '0;
    mb       = '0;
    case (cmd.msel)
      MUL_RR: begin
        ma = MUL_W'(r_q);
        mb = MUL_W'(r_q);
      end
      MUL_PP: begin
        ma = MUL_W'(p_q);
        mb = MUL_W'(p_q);
      end
      MUL_R_DM: begin
        ma = $signed({17'b0, r_abs});
        mb = $signed({2'b0, mag - DEAD_ZONE_Q30});
      end
      MUL_P_DM: begin
        ma = $signed({17'b0, p_abs});
        mb = $signed({2'b0, mag - DEAD_ZONE_Q30});
      end
      MUL_X0_C1: begin ma = x0; mb = c1; end
      MUL_Y0_S1: begin ma = y0; mb = s1; end
      MUL_X0_S1: begin ma = x0; mb = s1; end
      MUL_Y0_C1: begin ma = y0; mb = c1; end
      MUL_X1_S2: begin ma = x1; mb = s2; end
      MUL_Y2_C2: begin ma = y2; mb = c2; end
      MUL_X1_C2: begin ma = x1; mb = c2; end
      MUL_Y2_S2: begin ma = y2; mb = s2; end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mul_full = ma * mb;
  end

  // Window test, square root, divider, CORDIC and commit arithmetic
  always_comb begin
    win_end = $signed({2'b00, step_length_phases}) - $signed({2'b00, window_end_margin});
    win_hit = (phase_count > window_start) &&
              ($signed({2'b00, phase_count}) <= win_end);

    sq_bit     = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
    sq_sum     = sq_res + sq_bit;
    gain_sq_in = (64'd1 << 60) + (64'd1 << (6'd60 - {cmd.idx, 1'b0}));

    dv_trial = {dv_rem, dv_lo[30]};
    dv_ge    = dv_trial >= {2'b00, dv_den};

    cr_dx = cy >>> cmd.idx;
    cr_dy = cx >>> cmd.idx;
    cr_at = $signed({2'b00, ATAN_Q30[cmd.idx]});

    term_neg = cmd.idx[0] ? p_q[15] : (r_q[15] ^ left_q);
    term_v   = term_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

    lat_u = to_units(lat_v);
    fwd_u = to_units(fwd_v);
    h_u   = to_units(acc[63:30]);
    lat_c = (lat_u < 0) ? 12'd0 : ((lat_u > LAT_MAX) ? 12'd2880 : lat_u[11:0]);
    fwd_c = (fwd_u < -FWD_MAX) ? -13'sd2880 :
            ((fwd_u > FWD_MAX) ? 13'sd2880 : fwd_u[12:0]);
    h_c   = (h_u < 0) ? 15'd0 : ((h_u > HEIGHT_MAX) ? 15'd32767 : h_u[14:0]);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start       <= 8'd2;
      window_end_margin  <= 8'd2;
      step_length_phases <= 8'd25;
      half_foot_spacing  <= 13'd1280;
      nominal_height     <= 15'd12800;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START:      window_start       <= cfg_data[7:0];
        CFG_WINDOW_END_MARGIN: window_end_margin  <= cfg_data[7:0];
        CFG_STEP_LENGTH:       step_length_phases <= cfg_data[7:0];
        CFG_HALF_FOOT_SPACING: half_foot_spacing  <= cfg_data[12:0];
        CFG_NOMINAL_HEIGHT:    nominal_height     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiplier output and accumulator
  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
    case (cmd.amode)
      ACC_SET: acc <= prod;
      ACC_ADD: acc <= acc + prod;
      ACC_SUB: acc <= acc - prod;
      default: ;
    endcase
  end

  // Kept state, gain and status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lateral_acc   <= '0;
      forward_acc   <= '0;
      height_acc    <= 15'd12800;
      swing_lat_reg <= '0;
      swing_fwd_reg <= '0;
      gain          <= 31'd1 << 30;
      win_q         <= 1'b0;
      over_q        <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          win_q <= win_hit;
          if (restart) begin
            height_acc    <= nominal_height;
            lateral_acc   <= '0;
            forward_acc   <= '0;
            swing_lat_reg <= '0;
            swing_fwd_reg <= '0;
          end
        end
        OP_GAIN_SAVE: gain   <= dv_q;
        OP_MAG_SAVE:  over_q <= sq_res[31:0] > DEAD_ZONE_Q30;
        OP_COMMIT: begin
          lateral_acc   <= lat_c;
          forward_acc   <= fwd_c;
          height_acc    <= h_c;
          // the parallel-leg correction never fires: its sum is twice lateral
          swing_lat_reg <= {3'b000, lat_c};
          swing_fwd_reg <= -fwd_c;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the units
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        r_q    <= roll_angle;
        p_q    <= pitch_angle;
        left_q <= support_is_left;
      end
      OP_GAIN_SQ_LOAD: begin
        sq_v   <= gain_sq_in;
        sq_res <= '0;
      end
      OP_MAG_SQ_LOAD: begin
        sq_v   <= {acc[31:0], 32'b0};
        sq_res <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_v >= sq_sum) begin
          sq_v   <= sq_v - sq_sum;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
      end
      OP_MAG_SAVE: mag <= sq_res[31:0];
      OP_GAIN_DIV_LOAD: begin
        // dividend gain << 30
        dv_rem <= {3'b000, gain[30:1]};
        dv_lo  <= {gain[0], 30'b0};
        dv_den <= sq_res[31:0];
        dv_q   <= '0;
      end
      OP_TERM_DIV_LOAD: begin
        // dividend prod << 14
        dv_rem <= prod[49:17];
        dv_lo  <= {prod[16:0], 14'b0};
        dv_den <= mag;
        dv_q   <= '0;
      end
      OP_DIV_STEP: begin
        dv_rem <= dv_ge ? 33'(dv_trial - {2'b00, dv_den}) : dv_trial[32:0];
        dv_lo  <= {dv_lo[29:0], 1'b0};
        dv_q   <= {dv_q[29:0], dv_ge};
      end
      OP_TERM_SAVE: begin
        if (cmd.idx[0]) pt <= term_v;
        else            rt <= term_v;
      end
      OP_TERM_ZERO: begin
        rt <= '0;
        pt <= '0;
      end
      OP_CRD_LOAD: begin
        cx <= $signed({3'b000, gain});
        cy <= '0;
        cz <= cmd.idx[0] ? {pt[31], pt} : {rt[31], rt};
      end
      OP_CRD_STEP: begin
        if (!cz[32]) begin
          cx <= cx - cr_dx;
          cy <= cy + cr_dy;
          cz <= cz - cr_at;
        end else begin
          cx <= cx + cr_dx;
          cy <= cy - cr_dy;
          cz <= cz + cr_at;
        end
      end
      OP_CRD_SAVE: begin
        if (cmd.idx[0]) begin
          c2 <= cx;
          s2 <= cy;
        end else begin
          c1 <= cx;
          s1 <= cy;
        end
      end
      OP_ROT_SAVE: begin
        case (cmd.idx[1:0])
          2'd0:    x1    <= acc[63:30];
          2'd1:    lat_v <= acc[63:30] + $signed({7'b0, half_foot_spacing, 14'b0});
          default: fwd_v <= acc[63:30];
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      corrected      <= win_q;
      lateral_offset <= lateral_acc;
      forward_offset <= forward_acc;
      swing_lateral  <= swing_lat_reg;
      swing_forward  <= swing_fwd_reg;
      hip_height     <= height_acc;
    end
  end

endmodule

### hdl/tilt_compensated_foot_placement_core.sv
// ----------------------------------------------------------------------------
// tilt_compensated_foot_placement_core
// Balance correction of foot placement from filtered body roll and pitch.
// ----------------------------------------------------------------------------
// One item is processed at a time and yields exactly one result. After
// reset the core forms the CORDIC gain with its square-root and divide
// units and accepts no item until then. Configuration writes take effect
// at once, so write registers only while no item is in flight. Each item
// runs the 32-step square root; when the tilt is past the dead zone it also
// runs the two 31-step divides, and inside the gait window the two CORDIC
// passes and the leg rotation. The next item is accepted while the previous
// result still waits in the output register.
module tilt_compensated_foot_placement_core
  import tcfp_pkg::*;
#(
  parameter int CORDIC_ITERS = 16
) (
  input  logic         clk,
  input  logic         rst,
  tcfp_item_if.sink    item,
  tcfp_result_if.source result,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data
);

`include "tilt_compensated_foot_placement_core_defines.svh"

  tcfp_cmd_t  cmd;
  tcfp_stat_t stat;

  // Sequencer
  tcfp_ctrl #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Arithmetic and state
  tcfp_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .roll_angle      (item.roll_angle),
    .pitch_angle     (item.pitch_angle),
    .phase_count     (item.phase_count),
    .support_is_left (item.support_is_left),
    .restart         (item.restart),
    .corrected       (result.corrected),
    .lateral_offset  (result.lateral_offset),
    .forward_offset  (result.forward_offset),
    .swing_lateral   (result.swing_lateral),
    .swing_forward   (result.swing_forward),
    .hip_height      (result.hip_height)
  );

  // support_leg only picks the side of the parallel-leg sum, which never
  // goes negative, so the swing targets do not depend on it.

  // Checks
  `TCFP_ASSERT_NXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `TCFP_ASSERT_IMP(a_lateral_range, clk, rst, result.valid, result.lateral_offset <= 12'd2880)
  `TCFP_ASSERT_IMP(a_swing_lat, clk, rst, result.valid, result.swing_lateral == 15'(result.lateral_offset))
  `TCFP_ASSERT_IMP(a_swing_fwd, clk, rst, result.valid, result.swing_forward == -result.forward_offset)

endmodule

### sim/tb_tilt_compensated_foot_placement_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_foot_placement_core
// Streams control ticks through the foot placement core under several
// register settings. A bit-accurate predictor of the tilt dead zone, the
// CORDIC leg rotation and the clamps builds the expected results, which the
// monitor compares field by field. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_foot_placement_core;
  import tcfp_pkg::*;

  localparam int          ITERS       = 16;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          LONG_HOLD   = 3000;
  localparam logic [2:0]  CFG_UNUSED  = 3'd7;
  localparam longint      DEAD_ZONE   = 35433480;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic [7:0]         phase;
    logic               left;
    logic               leg;
    logic               restart;
  } tick_t;

  typedef struct {
    logic               corrected;
    logic [11:0]        lateral;
    logic signed [12:0] forward;
    logic [14:0]        swing_lat;
    logic signed [12:0] swing_fwd;
    logic [14:0]        height;
  } placement_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;

  tcfp_item_if   item_ch ();
  tcfp_result_if res_ch ();

  tilt_compensated_foot_placement_core #(.CORDIC_ITERS(ITERS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tick_t      tick_queue[$];
  placement_t placement_queue[$];
  tick_t      tick_on_bus;
  int         fail_count = 0;

  // Predictor copy of registers and state
  longint unsigned win_start, win_margin, step_len, half_spacing, nom_height;
  longint          lat_acc, fwd_acc, hgt_acc, swing_lat_acc, swing_fwd_acc;
  longint          cordic_gain;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint gain_of_iters();
    longint unsigned g, q;
    g = 64'd1 << 30;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      q = int_sqrt((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
      g = (g << 30) / q;
    end
    return longint'(g);
  endfunction

  // Rotate the gain-scaled unit vector by angle z (Q30)
  task automatic unit_rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = cordic_gain;
    y = 0;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
      end
    end
    c = x;
    s = y;
  endtask

  // Share of one axis in the tilt past the dead zone
  function automatic longint tilt_share(longint a, longint unsigned mag);
    longint unsigned ab, q;
    ab = (a < 0) ? longint'(-a) : longint'(a);
    q = ((ab * (mag - DEAD_ZONE)) << 14) / mag;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_units(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic predict_placement(input tick_t t);
    longint r, p, rt, pt, c, s, x, y, x1, lat, fwd, h, swl, ka, kb, sw;
    longint unsigned mag;
    placement_t res;
    r = t.roll;
    p = t.pitch;
    rt = 0;
    pt = 0;
    mag = int_sqrt(longint'(r * r + p * p) << 32);
    res.corrected = 1'b0;
    if (t.restart) begin
      hgt_acc = nom_height;
      lat_acc = 0; fwd_acc = 0; swing_lat_acc = 0; swing_fwd_acc = 0;
    end
    if (mag > DEAD_ZONE) begin
      rt = tilt_share(r, mag);
      pt = tilt_share(p, mag);
    end
    if (t.left) rt = -rt;
    if (longint'(t.phase) > longint'(win_start) &&
        longint'(t.phase) <= longint'(step_len) - longint'(win_margin)) begin
      res.corrected = 1'b1;
      sw = half_spacing;
      // Lateral rotation by roll, then forward rotation by pitch
      unit_rotate(rt, c, s);
      x = hgt_acc * 16384;
      y = (lat_acc - sw) * 16384;
      x1 = (x * c - y * s) >>> 30;
      lat = ((x * s + y * c) >>> 30) + sw * 16384;
      unit_rotate(pt, c, s);
      y = fwd_acc * 16384;
      fwd = (x1 * s + y * c) >>> 30;
      h = (x1 * c - y * s) >>> 30;
      lat_acc = clip(round_units(lat), 0, 2880);
      fwd_acc = clip(round_units(fwd), -2880, 2880);
      hgt_acc = clip(round_units(h), 0, 32767);
      // Parallel-leg correction of the swing foot
      swl = lat_acc;
      if (!t.leg) begin
        ka = lat_acc - sw; kb = sw + swl;
      end else begin
        kb = lat_acc - sw; ka = sw + swl;
      end
      if (ka + kb < 0) swl = swl - (ka + kb);
      swing_lat_acc = clip(swl, 0, 32767);
      swing_fwd_acc = -fwd_acc;
    end
    res.lateral   = lat_acc[11:0];
    res.forward   = fwd_acc[12:0];
    res.swing_lat = swing_lat_acc[14:0];
    res.swing_fwd = swing_fwd_acc[12:0];
    res.height    = hgt_acc[14:0];
    placement_queue.push_back(res);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_WINDOW_START:      win_start    = val[7:0];
      CFG_WINDOW_END_MARGIN: win_margin   = val[7:0];
      CFG_STEP_LENGTH:       step_len     = val[7:0];
      CFG_HALF_FOOT_SPACING: half_spacing = val[12:0];
      CFG_NOMINAL_HEIGHT:    nom_height   = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int ws, input int wm, input int sl, input int hs,
                           input int nh);
    write_reg(CFG_WINDOW_START, 15'(ws));
    write_reg(CFG_WINDOW_END_MARGIN, 15'(wm));
    write_reg(CFG_STEP_LENGTH, 15'(sl));
    write_reg(CFG_HALF_FOOT_SPACING, 15'(hs));
    write_reg(CFG_NOMINAL_HEIGHT, 15'(nh));
    write_reg(CFG_UNUSED, 15'($urandom));
  endtask

  task automatic add_tick(input int r, input int p, input int ph, input bit lf,
                          input bit lg, input bit rs);
    tick_t t;
    t.roll = 16'(r);
    t.pitch = 16'(p);
    t.phase = 8'(ph);
    t.left = lf;
    t.leg = lg;
    t.restart = rs;
    tick_queue.push_back(t);
  endtask

  function automatic int small_angle();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 9000)) - 4500;
  endfunction

  // Mostly whole steps with walking phase; the rest is noise
  task automatic add_walk(input int count);
    int n, lim;
    bit lf;
    n = 0;
    lf = 1'b0;
    while (n < count) begin
      if ($urandom_range(0, 6) == 0) begin
        add_tick(small_angle(), small_angle(), $urandom_range(0, 255),
                 1'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end else begin
        lim = (step_len > 60) ? 60 : int'(step_len);
        for (int ph = 0; ph <= lim && n < count; ph++) begin
          add_tick(small_angle(), small_angle(), ph, lf,
                   ($urandom_range(0, 9) == 0) ? ~lf : lf,
                   (ph == 0) && ($urandom_range(0, 3) == 0));
          n++;
        end
        lf = ~lf;
      end
    end
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || item_ch.valid || placement_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      fail_count++;
    end
  endtask

  // Sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_placement(tick_on_bus);
        void'(tick_queue.pop_front());
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_ch.valid <= 1'b0;
        end else if (tick_queue.size() > ((item_ch.valid && item_ch.ready) ? 0 : 0)
                     && tick_queue.size() > 0) begin
          tick_on_bus = tick_queue[0];
          item_ch.roll_angle      <= tick_on_bus.roll;
          item_ch.pitch_angle     <= tick_on_bus.pitch;
          item_ch.phase_count     <= tick_on_bus.phase;
          item_ch.support_is_left <= tick_on_bus.left;
          item_ch.support_leg     <= tick_on_bus.leg;
          item_ch.restart         <= tick_on_bus.restart;
          item_ch.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  bit stall_mode = 1'b0;
  int results_seen = 0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!held_once && results_seen >= 150) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 2000);
        stall_mode <= 1'($urandom_range(0, 1));
      end else begin
        mode_left <= mode_left - 1;
      end
      res_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    placement_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      if (placement_queue.size() == 0) begin
        $error("result with no expected item pending");
        fail_count++;
      end else begin
        e = placement_queue.pop_front();
        check_field("corrected", e.corrected, res_ch.corrected);
        check_field("lateral_offset", e.lateral, res_ch.lateral_offset);
        check_field("forward_offset", e.forward, res_ch.forward_offset);
        check_field("swing_lateral", e.swing_lat, res_ch.swing_lateral);
        check_field("swing_forward", e.swing_fwd, res_ch.swing_forward);
        check_field("hip_height", e.height, res_ch.hip_height);
      end
    end
  end

  // Watchdog on cycles with no item moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.roll_angle = '0;
    item_ch.pitch_angle = '0;
    item_ch.phase_count = '0;
    item_ch.support_is_left = 1'b0;
    item_ch.support_leg = 1'b0;
    item_ch.restart = 1'b0;
    res_ch.ready = 1'b0;
    cordic_gain = gain_of_iters();
    win_start = 2; win_margin = 2; step_len = 25; half_spacing = 1280;
    nom_height = 12800;
    lat_acc = 0; fwd_acc = 0; hgt_acc = 12800; swing_lat_acc = 0; swing_fwd_acc = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at reset settings
    add_tick(0, 0, 5, 0, 0, 0);
    add_tick(540, 0, 5, 0, 0, 0);
    add_tick(541, 0, 5, 0, 0, 0);
    add_tick(32767, 32767, 10, 0, 0, 0);
    add_tick(-32768, -32768, 10, 1, 1, 0);
    add_tick(-32768, 32767, 12, 0, 1, 0);
    add_tick(32767, -32768, 12, 1, 0, 0);
    add_tick(3000, -2000, 2, 0, 0, 0);
    add_tick(3000, -2000, 3, 0, 0, 0);
    add_tick(3000, -2000, 23, 1, 1, 0);
    add_tick(3000, -2000, 24, 0, 0, 0);
    add_tick(-4000, 4000, 0, 1, 0, 1);
    add_tick(-4000, 4000, 255, 1, 0, 0);
    add_tick(1500, 1500, 8, 0, 0, 1);
    add_tick(-32768, 0, 9, 0, 0, 0);
    add_tick(0, -32768, 9, 1, 1, 0);
    add_walk(200);
    wait_drained();

    // Widest window and extreme geometry
    write_all(0, 0, 255, 6400, 32767);
    add_tick(20000, -20000, 0, 0, 0, 1);
    add_tick(-20000, 20000, 255, 1, 1, 0);
    add_tick(0, 0, 1, 0, 1, 0);
    add_walk(220);
    wait_drained();

    // Negative window end and zero height
    write_all(255, 255, 1, 0, 0);
    add_tick(5000, 5000, 1, 0, 0, 1);
    add_walk(60);
    wait_drained();
    write_all(0, 0, 40, 0, 0);
    add_tick(5000, 5000, 5, 0, 0, 1);
    add_tick(-5000, 3000, 6, 1, 1, 0);
    add_walk(160);
    wait_drained();

    // Random settings
    for (int k = 0; k < 3; k++) begin
      write_all($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(10, 40),
                $urandom_range(0, 6400), $urandom_range(0, 32767));
      add_walk(150);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0 && placement_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
